// File: rtl/core/wlvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wlvc_pkg
// Shared types and constants for the windowed label vote block.
// ----------------------------------------------------------------------------
package wlvc_pkg;

	localparam int LABEL_W    = 8;
	localparam int VOTE_W     = 11;
	localparam int NUML_W     = 5;
	localparam int POS_W      = 32;
	localparam int WINNER_W   = 4;
	localparam int CONF_W     = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// votes * scale stays below 2^26 for an 11-bit vote count
	localparam int DIVIDEND_W = 26;
	localparam int DIV_CNT_W  = 5;

	localparam logic [VOTE_W-1:0]     VOTE_MAX   = '1;
	localparam logic [CONF_W-1:0]     CONF_SCALE = 15'd25600;
	localparam logic [VOTE_W-1:0]     WIN_RESET  = 11'd40;
	localparam logic [NUML_W-1:0]     NUML_RESET = 5'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH = 2'd0,
		CFG_NUM_LABELS    = 2'd1,
		CFG_FORCE_REPORT  = 2'd2,
		CFG_MUTE          = 2'd3
	} cfg_idx_t;

	// command to the vote counter bank
	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} vote_cmd_t;

endpackage : wlvc_pkg
`default_nettype wire

// File: rtl/core/windowed_label_vote_confidence.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_label_vote_confidence
// Counts one label vote per unmuted frame and reports the winning label of each
// window with its vote count and a Q8 percent confidence.
//
// Input channel: in_valid/in_stall with label. Output channel: out_valid/
// out_stall with frame_position, winner_label, winner_votes, confidence_q8
// and label_changed. A transfer happens when valid is high and stall is low.
// Configuration: cfg_we with cfg_index/cfg_data, write only while idle.
// One frame is processed at a time; in_stall is high while it is in work.
// A muted frame is taken in idle and casts no vote; a frame that closes no
// window reads and writes its counter. A frame that closes a window then walks
// the counter bank with a read and a compare per label in use, multiplies, and
// runs a bit-serial divide of the 26-bit dividend. The report sits in an output
// register; while it is stalled the next frames are still taken, and only a
// further report waits.
// Reset clears all counters, sets window 40, labels 2, position -39.
// ----------------------------------------------------------------------------
module windowed_label_vote_confidence
	import wlvc_pkg::*;
#(
	parameter int MAX_LABELS = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  wire  [CFG_IDX_W-1:0]    cfg_index,
	input  wire  [CFG_DATA_W-1:0]   cfg_data,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire  [LABEL_W-1:0]      label,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic signed [POS_W-1:0] frame_position,
	output logic [WINNER_W-1:0]     winner_label,
	output logic [VOTE_W-1:0]       winner_votes,
	output logic [CONF_W-1:0]       confidence_q8,
	output logic                    label_changed
);

	localparam int LW = $clog2(MAX_LABELS);
	localparam int UW = $clog2(MAX_LABELS + 1);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_RD       = 9'b000000010,
		S_WR       = 9'b000000100,
		S_SCAN_RD  = 9'b000001000,
		S_SCAN_CMP = 9'b000010000,
		S_MUL      = 9'b000100000,
		S_DIV_GO   = 9'b001000000,
		S_DIV      = 9'b010000000,
		S_OUT      = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic [VOTE_W-1:0]     win_len_q;
	logic [NUML_W-1:0]     num_labels_q;
	logic                  force_q;
	logic                  mute_q;
	logic [POS_W-1:0]      pos_cnt_q;
	logic [VOTE_W-1:0]     frames_q;
	logic [WINNER_W-1:0]   last_win_q;
	logic                  last_vld_q;
	logic                  out_valid_q;
	logic [UW-1:0]         scan_q;
	logic [LW-1:0]         best_q;
	logic [VOTE_W-1:0]     best_votes_q;

	logic [LABEL_W-1:0]    label_q;
	logic                  in_use_q;
	logic [POS_W-1:0]      pos_q;
	logic [DIVIDEND_W-1:0] prod_q;

	logic [UW-1:0]         used;
	logic [VOTE_W-1:0]     win_eff;
	logic                  in_acc;
	logic                  scan_more;
	logic                  out_load;
	logic [WINNER_W-1:0]   winner4;
	logic [31:0]           best_ext;

	vote_cmd_t             vcmd;
	logic [LW-1:0]         vaddr;
	logic [VOTE_W-1:0]     vwdata;
	logic [VOTE_W-1:0]     vrdata;
	logic                  div_start;
	logic                  div_done;
	logic [CONF_W-1:0]     div_quo;

	assign used      = (32'(num_labels_q) > MAX_LABELS) ? UW'(MAX_LABELS)
							: UW'(num_labels_q);
	assign win_eff   = (win_len_q == '0) ? VOTE_W'(1) : win_len_q;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && (state_q == S_IDLE);
	assign scan_more = (32'(scan_q) < 32'(used));
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign best_ext  = 32'(best_q);
	assign winner4   = best_ext[WINNER_W-1:0];

	always_comb begin
		state_d   = state_q;
		vcmd      = '0;
		vaddr     = label_q[LW-1:0];
		vwdata    = vrdata + 1'b1;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && !mute_q) state_d = S_RD;
			end
			S_RD: begin
				vcmd.rd = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				vcmd.wr = in_use_q && (vrdata != VOTE_MAX);
				state_d = (frames_q >= win_eff || force_q) ? S_SCAN_RD : S_IDLE;
			end
			S_SCAN_RD: begin
				vaddr   = scan_q[LW-1:0];
				vcmd.rd = scan_more;
				state_d = scan_more ? S_SCAN_CMP : S_MUL;
			end
			S_SCAN_CMP: state_d = S_SCAN_RD;
			S_MUL:      state_d = S_DIV_GO;
			S_DIV_GO: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_done) state_d = S_OUT;
			end
			S_OUT: begin
				vcmd.clr = out_load;
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			win_len_q    <= WIN_RESET;
			num_labels_q <= NUML_RESET;
			force_q      <= 1'b0;
			mute_q       <= 1'b0;
			pos_cnt_q    <= POS_W'(1) - POS_W'(WIN_RESET);
			frames_q     <= '0;
			last_win_q   <= '0;
			last_vld_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			scan_q       <= '0;
			best_q       <= '0;
			best_votes_q <= '0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_WINDOW_LENGTH: begin
						win_len_q  <= cfg_data[VOTE_W-1:0];
						pos_cnt_q  <= POS_W'(1) - POS_W'(cfg_data[VOTE_W-1:0]);
						last_vld_q <= 1'b0;
					end
					CFG_NUM_LABELS:   num_labels_q <= cfg_data[NUML_W-1:0];
					CFG_FORCE_REPORT: force_q      <= cfg_data[0];
					CFG_MUTE:         mute_q       <= cfg_data[0];
					default: ;
				endcase
			end else if (in_acc) begin
				pos_cnt_q <= pos_cnt_q + 1'b1;
			end

			if (state_q == S_RD && frames_q != VOTE_MAX) begin
				frames_q <= frames_q + 1'b1;
			end

			if (state_q == S_WR) begin
				scan_q       <= '0;
				best_q       <= '0;
				best_votes_q <= '0;
			end

			// strict greater keeps the lowest index on a tie
			if (state_q == S_SCAN_CMP) begin
				scan_q <= scan_q + 1'b1;
				if (vrdata > best_votes_q) begin
					best_votes_q <= vrdata;
					best_q       <= scan_q[LW-1:0];
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				frames_q    <= '0;
				last_win_q  <= winner4;
				last_vld_q  <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			label_q  <= label;
			in_use_q <= (32'(label) < 32'(used));
			pos_q    <= pos_cnt_q;
		end
		if (state_q == S_MUL) begin
			prod_q <= DIVIDEND_W'(best_votes_q) * DIVIDEND_W'(CONF_SCALE);
		end
		if (out_load) begin
			frame_position <= pos_q;
			winner_label   <= winner4;
			winner_votes   <= best_votes_q;
			confidence_q8  <= div_quo;
			label_changed  <= !last_vld_q || (winner4 != last_win_q);
		end
	end

	assign out_valid = out_valid_q;

	wlvc_votes #(
		.DEPTH (MAX_LABELS),
		.AW    (LW)
	) u_votes (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (vcmd),
		.addr   (vaddr),
		.wdata  (vwdata),
		.rdata  (vrdata)
	);

	wlvc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (frames_q),
		.done     (div_done),
		.quotient (div_quo)
	);

endmodule : windowed_label_vote_confidence
`default_nettype wire

// File: rtl/core/wlvc_votes.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wlvc_votes
// Vote counter bank: single-port memory with registered read and per-entry
// valid bits so that a clear empties every entry at once.
// ----------------------------------------------------------------------------
module wlvc_votes
	import wlvc_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire  vote_cmd_t    cmd,
	input  wire  [AW-1:0]      addr,
	input  wire  [VOTE_W-1:0]  wdata,
	output logic [VOTE_W-1:0]  rdata
);

	logic [VOTE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [VOTE_W-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.clr) begin
			vld_q <= '0;
		end else if (cmd.wr) begin
			vld_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= vld_q[addr] ? mem[addr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule : wlvc_votes
`default_nettype wire

// File: rtl/core/wlvc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wlvc_div
// Restoring divider, one quotient bit per cycle. Quotient holds after done.
// ----------------------------------------------------------------------------
module wlvc_div
	import wlvc_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	input  wire  [DIVIDEND_W-1:0]  dividend,
	input  wire  [VOTE_W-1:0]      divisor,
	output logic                   done,
	output logic [CONF_W-1:0]      quotient
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVIDEND_W-1:0] acc_q;
	logic [VOTE_W-1:0]     rem_q;
	logic [VOTE_W:0]       trial;
	logic                  qbit;

	assign trial = {rem_q, acc_q[DIVIDEND_W-1]};
	assign qbit  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[DIVIDEND_W-2:0], qbit};
			rem_q <= qbit ? VOTE_W'(trial - {1'b0, divisor}) : trial[VOTE_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = acc_q[CONF_W-1:0];

endmodule : wlvc_div
`default_nettype wire
